// File: rtl/http_request_header_parser_assert.svh
// assertion macros included by the parse state module
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HRHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hrhp_pkg.sv
// shared types, keyword tables and helper functions of the request header parser
package hrhp_pkg;

	localparam int LEN_W = 32;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_BAD        = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEC_REQ  = 2'd0,
		SEC_HDR  = 2'd1,
		SEC_BODY = 2'd2
	} sec_t;

	typedef enum logic [12:0] {
		F_RL_METHOD   = 13'h0001,
		F_RL_SEP1     = 13'h0002,
		F_RL_PREFIX   = 13'h0004,
		F_RL_SEEK     = 13'h0008,
		F_RL_PATH     = 13'h0010,
		F_RL_SEP2     = 13'h0020,
		F_RL_VERSION  = 13'h0040,
		F_H_NAME      = 13'h0080,
		F_H_CONN_SKIP = 13'h0100,
		F_H_CONN_VAL  = 13'h0200,
		F_H_LEN_SKIP  = 13'h0400,
		F_H_LEN_DIGIT = 13'h0800,
		F_H_OTHER     = 13'h1000
	} fld_t;

	typedef enum logic [2:0] {
		KW_GET   = 3'd0,
		KW_POST  = 3'd1,
		KW_HTTP  = 3'd2,
		KW_HTTPS = 3'd3,
		KW_VER   = 3'd4,
		KW_CONN  = 3'd5,
		KW_CLEN  = 3'd6,
		KW_KA    = 3'd7
	} kw_t;

	localparam logic [7:0] KS_GET [3] = '{"g", "e", "t"};
	localparam logic [7:0] KS_POST [4] = '{"p", "o", "s", "t"};
	localparam logic [7:0] KS_HTTP [7] = '{"h", "t", "t", "p", ":", "/", "/"};
	localparam logic [7:0] KS_HTTPS [8] = '{"h", "t", "t", "p", "s", ":", "/", "/"};
	localparam logic [7:0] KS_VER [8] = '{"h", "t", "t", "p", "/", "1", ".", "1"};
	localparam logic [7:0] KS_CONN [11] =
		'{"c", "o", "n", "n", "e", "c", "t", "i", "o", "n", ":"};
	localparam logic [7:0] KS_CLEN [15] =
		'{"c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"};
	localparam logic [7:0] KS_KA [10] = '{"k", "e", "e", "p", "-", "a", "l", "i", "v", "e"};

	typedef struct packed {
		sec_t             sec;
		fld_t             fld;
		logic [4:0]       pos;
		logic [1:0]       cand;
		logic             cr;
		logic             empty;
		logic             meth;
		logic             linger;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] bcnt;
		status_t          outcome;
	} pstate_t;

	localparam pstate_t RESET_ST = '{
		sec:     SEC_REQ,
		fld:     F_RL_METHOD,
		pos:     5'd0,
		cand:    2'b11,
		cr:      1'b0,
		empty:   1'b1,
		meth:    1'b0,
		linger:  1'b0,
		len:     '0,
		bcnt:    '0,
		outcome: ST_INCOMPLETE
	};

	typedef struct packed {
		status_t          status;
		logic             method;
		logic             persist;
		logic [LEN_W-1:0] body_len;
		logic [7:0]       path_byte;
		logic             path_valid;
		logic             body_valid;
		sec_t             section;
	} res_t;

	function automatic logic [7:0] fold(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [4:0] adv(logic [4:0] p);
		return (p == 5'd31) ? p : p + 5'd1;
	endfunction

	function automatic logic kw_hit(kw_t kw, logic [4:0] pos, logic [7:0] c);
		logic [7:0] f;
		logic       h;
		f = fold(c);
		h = 1'b0;
		unique case (kw)
			KW_GET:   h = (pos < 5'd3) && (f == KS_GET[pos[1:0]]);
			KW_POST:  h = (pos < 5'd4) && (f == KS_POST[pos[1:0]]);
			KW_HTTP:  h = (pos < 5'd7) && (f == KS_HTTP[pos[2:0]]);
			KW_HTTPS: h = (pos < 5'd8) && (f == KS_HTTPS[pos[2:0]]);
			KW_VER:   h = (pos < 5'd8) && (f == KS_VER[pos[2:0]]);
			KW_CONN:  h = (pos < 5'd11) && (f == KS_CONN[pos[3:0]]);
			KW_CLEN:  h = (pos < 5'd15) && (f == KS_CLEN[pos[3:0]]);
			KW_KA:    h = (pos < 5'd10) && (f == KS_KA[pos[3:0]]);
		endcase
		return h;
	endfunction

endpackage

// File: rtl/hrhp_byte_if.sv
// request channel carrying one byte of the incoming stream
interface hrhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// File: rtl/hrhp_res_if.sv
// result channel carrying the parse outcome of one byte
interface hrhp_res_if import hrhp_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             method;
	logic             persist;
	logic [LEN_W-1:0] body_len;
	logic [7:0]       path_byte;
	logic             path_valid;
	logic             body_valid;
	logic [1:0]       section;

	modport source (output valid, output status, output method, output persist,
		output body_len, output path_byte, output path_valid, output body_valid,
		output section, input ready);
	modport sink (input valid, input status, input method, input persist,
		input body_len, input path_byte, input path_valid, input body_valid,
		input section, output ready);
endinterface

// File: rtl/hrhp_len.sv
// length arithmetic: saturating decimal digit accumulate and body byte count
module hrhp_len import hrhp_pkg::*; (
	input  logic [LEN_W-1:0] len,
	input  logic [3:0]       digit,
	input  logic [LEN_W-1:0] bcnt,
	output logic [LEN_W-1:0] len_next,
	output logic [LEN_W-1:0] bcnt_next,
	output logic             body_done
);

	logic [LEN_W+3:0] acc;

	// len * 10 + digit, saturating at the top of the range
	assign acc = {1'b0, len, 3'b000} + {3'b000, len, 1'b0} + {{LEN_W{1'b0}}, digit};
	assign len_next = (|acc[LEN_W+3:LEN_W]) ? {LEN_W{1'b1}} : acc[LEN_W-1:0];

	assign bcnt_next = bcnt + {{(LEN_W-1){1'b0}}, 1'b1};
	assign body_done = (bcnt_next >= len);

endmodule

// File: rtl/hrhp_parse.sv
// parse state registers and the combinational next-state step for one byte
module hrhp_parse import hrhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output res_t       res
);

	`include "http_request_header_parser_assert.svh"

	pstate_t          state_q;
	pstate_t          cur;
	pstate_t          nx;
	logic             sp;
	logic             dig;
	logic             pv;
	logic             bv;
	logic [4:0]       pos_adv;
	logic             m_c0, m_c1;
	logic             n_c0, n_c1;
	logic [1:0]       pre_c;
	logic [4:0]       pre_p;
	logic [4:0]       pre_np;
	logic             pre_c0, pre_c1;
	logic [4:0]       ver_p;
	logic             ver_c0, ver_c1;
	logic [4:0]       ka_p;
	logic             ka_c0, ka_c1;
	logic [LEN_W-1:0] len_mac;
	logic [LEN_W-1:0] bcnt_inc;
	logic             body_done;

	assign cur = first_byte ? RESET_ST : state_q;

	hrhp_len u_len (
		.len       (cur.len),
		.digit     (data_byte[3:0]),
		.bcnt      (cur.bcnt),
		.len_next  (len_mac),
		.bcnt_next (bcnt_inc),
		.body_done (body_done)
	);

	always_comb begin
		sp      = (data_byte == CH_SP) || (data_byte == CH_TAB);
		dig     = (data_byte >= "0") && (data_byte <= "9");
		pos_adv = adv(cur.pos);

		m_c0 = cur.cand[0] & kw_hit(KW_GET, cur.pos, data_byte);
		m_c1 = cur.cand[1] & kw_hit(KW_POST, cur.pos, data_byte);
		n_c0 = cur.cand[0] & kw_hit(KW_CONN, cur.pos, data_byte);
		n_c1 = cur.cand[1] & kw_hit(KW_CLEN, cur.pos, data_byte);

		// host prefix restarts its match on the first non-blank byte after the method
		pre_c  = (cur.fld == F_RL_SEP1) ? 2'b11 : cur.cand;
		pre_p  = (cur.fld == F_RL_SEP1) ? 5'd0 : cur.pos;
		pre_c0 = pre_c[0] & kw_hit(KW_HTTP, pre_p, data_byte);
		pre_c1 = pre_c[1] & kw_hit(KW_HTTPS, pre_p, data_byte);
		pre_np = adv(pre_p);

		ver_p  = (cur.fld == F_RL_SEP2) ? 5'd0 : cur.pos;
		ver_c0 = ((cur.fld == F_RL_SEP2) ? 1'b1 : cur.cand[0])
			& kw_hit(KW_VER, ver_p, data_byte);
		ver_c1 = (cur.fld == F_RL_SEP2) ? 1'b0 : cur.cand[1];

		ka_p  = (cur.fld == F_H_CONN_SKIP) ? 5'd0 : cur.pos;
		ka_c0 = ((cur.fld == F_H_CONN_SKIP) ? 1'b1 : cur.cand[0])
			& kw_hit(KW_KA, ka_p, data_byte);
		ka_c1 = (cur.fld == F_H_CONN_SKIP) ? 1'b0 : cur.cand[1];
	end

	always_comb begin
		nx = cur;
		pv = 1'b0;
		bv = 1'b0;
		if (cur.outcome == ST_INCOMPLETE) begin
			if (cur.sec == SEC_BODY) begin
				bv      = 1'b1;
				nx.bcnt = bcnt_inc;
				if (body_done) begin
					nx.outcome = ST_COMPLETE;
				end
			end else if (cur.cr) begin
				if (data_byte == CH_LF) begin
					// end of line
					if (cur.sec == SEC_REQ) begin
						nx.sec = SEC_HDR;
					end else if (cur.empty) begin
						if (cur.len != '0) begin
							nx.sec  = SEC_BODY;
							nx.bcnt = '0;
						end else begin
							nx.outcome = ST_COMPLETE;
						end
					end else if (cur.fld == F_H_CONN_VAL && cur.cand[0] && cur.pos == 5'd10) begin
						nx.linger = 1'b1;
					end
					nx.fld   = F_H_NAME;
					nx.cand  = 2'b11;
					nx.pos   = 5'd0;
					nx.empty = 1'b1;
					nx.cr    = 1'b0;
				end else begin
					nx.outcome = ST_BAD;
				end
			end else if (data_byte == CH_CR) begin
				if (cur.sec == SEC_REQ &&
					!(cur.fld == F_RL_VERSION && cur.cand[0] && cur.pos == 5'd8)) begin
					nx.outcome = ST_BAD;
				end else begin
					nx.cr = 1'b1;
				end
			end else if (data_byte == CH_LF) begin
				nx.outcome = ST_BAD;
			end else begin
				nx.empty = 1'b0;
				if (cur.sec == SEC_REQ) begin
					unique case (cur.fld) inside
						F_RL_METHOD: begin
							if (sp) begin
								if (cur.cand[0] && cur.pos == 5'd3) begin
									nx.meth = 1'b0;
								end else if (cur.cand[1] && cur.pos == 5'd4) begin
									nx.meth = 1'b1;
								end else begin
									nx.outcome = ST_BAD;
								end
								nx.fld = F_RL_SEP1;
							end else begin
								nx.cand = {m_c1, m_c0};
								nx.pos  = pos_adv;
								if (!m_c0 && !m_c1) begin
									nx.outcome = ST_BAD;
								end
							end
						end
						F_RL_SEP1, F_RL_PREFIX: begin
							if (sp) begin
								if (cur.fld == F_RL_PREFIX) begin
									nx.outcome = ST_BAD;
								end
							end else if (cur.fld == F_RL_SEP1 && data_byte == CH_SLASH) begin
								nx.fld = F_RL_PATH;
								pv     = 1'b1;
							end else begin
								nx.fld  = F_RL_PREFIX;
								nx.cand = {pre_c1, pre_c0};
								nx.pos  = pre_np;
								if ((pre_c0 && pre_np == 5'd7) || (pre_c1 && pre_np == 5'd8)) begin
									nx.fld = F_RL_SEEK;
								end else if (!pre_c0 && !pre_c1) begin
									nx.outcome = ST_BAD;
								end
							end
						end
						F_RL_SEEK: begin
							if (sp) begin
								nx.outcome = ST_BAD;
							end else if (data_byte == CH_SLASH) begin
								nx.fld = F_RL_PATH;
								pv     = 1'b1;
							end
						end
						F_RL_PATH: begin
							if (sp) begin
								nx.fld = F_RL_SEP2;
							end else begin
								pv = 1'b1;
							end
						end
						F_RL_SEP2, F_RL_VERSION: begin
							if (!(sp && cur.fld == F_RL_SEP2)) begin
								nx.fld  = F_RL_VERSION;
								nx.cand = {ver_c1, ver_c0};
								nx.pos  = adv(ver_p);
								if (!ver_c0 && !ver_c1) begin
									nx.outcome = ST_BAD;
								end
							end
						end
						default: begin
							nx.outcome = ST_BAD;
						end
					endcase
				end else begin
					unique case (cur.fld) inside
						F_H_NAME: begin
							nx.cand = {n_c1, n_c0};
							nx.pos  = pos_adv;
							if (n_c0 && pos_adv == 5'd11) begin
								nx.fld = F_H_CONN_SKIP;
							end else if (n_c1 && pos_adv == 5'd15) begin
								nx.fld = F_H_LEN_SKIP;
								nx.len = '0;
							end else if (!n_c0 && !n_c1) begin
								nx.fld = F_H_OTHER;
							end
						end
						F_H_CONN_SKIP, F_H_CONN_VAL: begin
							if (!(sp && cur.fld == F_H_CONN_SKIP)) begin
								nx.fld  = F_H_CONN_VAL;
								nx.cand = {ka_c1, ka_c0};
								nx.pos  = adv(ka_p);
							end
						end
						F_H_LEN_SKIP, F_H_LEN_DIGIT: begin
							if (dig) begin
								nx.fld = F_H_LEN_DIGIT;
								nx.len = len_mac;
							end else if (!(sp && cur.fld == F_H_LEN_SKIP)) begin
								nx.fld = F_H_OTHER;
							end
						end
						default: begin
							nx.fld = F_H_OTHER;
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		res.status     = nx.outcome;
		res.method     = nx.meth;
		res.persist    = nx.linger;
		res.body_len   = nx.len;
		res.path_byte  = pv ? data_byte : 8'd0;
		res.path_valid = pv;
		res.body_valid = bv;
		res.section    = nx.sec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RESET_ST;
		end else if (step_en) begin
			state_q <= nx;
		end
	end

	`HRHP_ASSERT_NEXT(a_outcome_sticky, step_en && !first_byte && state_q.outcome != ST_INCOMPLETE, $stable(state_q), "finished request changed state without a new start")
	`HRHP_ASSERT_NEXT(a_path_in_req_line, step_en && res.path_valid, state_q.sec == SEC_REQ && state_q.outcome == ST_INCOMPLETE, "path byte outside an open request line")
	`HRHP_ASSERT_NOW(a_body_count_bound, state_q.sec == SEC_BODY, state_q.bcnt < state_q.len || state_q.outcome == ST_COMPLETE, "body count ran past the content length")

endmodule

// File: rtl/http_request_header_parser.sv
// top level of the byte-wise http request header parser
// Takes one byte of the request stream per clock while results are taken, and returns one
// result per byte, in order. A byte accepted into the input register is parsed against the
// parse state combinationally, and its result is registered in the output register when the
// input register advances, which it does only while the output register is empty or its
// result is taken.
// While a result waits at the output the input register takes one more byte, then ready drops.
// Setting first_byte clears all parse state before that byte. After a complete or bad
// request, bytes give unchanged results until the next start.
module http_request_header_parser import hrhp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hrhp_byte_if.sink   bytes,
	hrhp_res_if.source  results
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res;
	logic       adv_s1;

	assign adv_s1      = valid_s1 && (!valid_s2 || results.ready);
	assign bytes.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1  <= bytes.data_byte;
			first_s1 <= bytes.first_byte;
		end
	end

	hrhp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (adv_s1),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign results.valid      = valid_s2;
	assign results.status     = res_s2.status;
	assign results.method     = res_s2.method;
	assign results.persist    = res_s2.persist;
	assign results.body_len   = res_s2.body_len;
	assign results.path_byte  = res_s2.path_byte;
	assign results.path_valid = res_s2.path_valid;
	assign results.body_valid = res_s2.body_valid;
	assign results.section    = res_s2.section;

endmodule
